### sv/cfrot_pkg.sv
// ----------------------------------------------------------------------------
// cfrot_pkg
// Shared types and codes for the circular fifo with rotate: beat payloads,
// command and status codes, controller states, control and status bundles.
// ----------------------------------------------------------------------------
package cfrot_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned PUSH_W   = 32;
  localparam int unsigned RD_W     = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_ROTATE = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [PUSH_W-1:0] push_data;
  } in_t;

  typedef struct packed {
    logic [RD_W-1:0]     read_data;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill_count;
    logic                is_empty;
    logic                is_full;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic    mem_rd;
    logic    mem_wr;
    logic    wr_rot;
    logic    head_inc;
    logic    tail_inc;
    logic    occ_inc;
    logic    occ_dec;
    logic    res_cap;
    status_e res_status;
    logic    res_use_rd;
    logic    out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic multi;
    logic out_free;
  } dp_stat_t;

endpackage

### sv/cfrot_ctrl.sv
// ----------------------------------------------------------------------------
// cfrot_ctrl
// Controller state machine: decodes each accepted command and sequences the
// memory access, pointer updates and the result beat.
// ----------------------------------------------------------------------------
module cfrot_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             in_command_i,
  input  cfrot_pkg::dp_stat_t    stat_i,
  output logic                   in_stall_o,
  output cfrot_pkg::ctrl_cmd_t   cmd_o
);
  import cfrot_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.res_cap = 1'b1;
          state_d       = S_RESP;
          if (in_command_i == CMD_PUSH) begin
            if (stat_i.full) begin
              cmd_o.res_status = ST_OVERFLOW;
            end else begin
              cmd_o.mem_wr   = 1'b1;
              cmd_o.tail_inc = 1'b1;
              cmd_o.occ_inc  = 1'b1;
            end
          end else if (stat_i.empty) begin
            cmd_o.res_status = ST_UNDERFLOW;
          end else begin
            case (cmd_e'(in_command_i))
              CMD_POP: begin
                cmd_o.mem_rd     = 1'b1;
                cmd_o.head_inc   = 1'b1;
                cmd_o.occ_dec    = 1'b1;
                cmd_o.res_use_rd = 1'b1;
              end
              CMD_PEEK: begin
                cmd_o.mem_rd     = 1'b1;
                cmd_o.res_use_rd = 1'b1;
              end
              CMD_ROTATE: begin
                // a single element rotates onto itself: nothing to do
                if (stat_i.multi) begin
                  cmd_o.mem_rd = 1'b1;
                  state_d      = S_ROT;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_ROT: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.wr_rot   = 1'b1;
        cmd_o.head_inc = 1'b1;
        cmd_o.tail_inc = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command accepted while previous one in flight");

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("result loaded over a pending beat");

  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.mem_rd && cmd_o.mem_wr))
    else $error("memory read and write in the same cycle");
`endif

endmodule

### sv/cfrot_dp.sv
// ----------------------------------------------------------------------------
// cfrot_dp
// Datapath: element memory, head/tail pointers, occupancy counter, result
// capture and the output register.
// ----------------------------------------------------------------------------
module cfrot_dp #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfrot_pkg::ctrl_cmd_t  cmd_i,
  input  cfrot_pkg::in_t        in_data_i,
  input  logic                  out_stall_i,
  output cfrot_pkg::dp_stat_t   stat_o,
  output logic                  out_valid_o,
  output cfrot_pkg::out_t       out_data_o
);
  import cfrot_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned OW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [OW-1:0]         occ_q, occ_d;
  logic [63:0]           push_ext, rd_ext;
  logic [31:0]           occ_ext;
  status_e               res_status_q;
  logic                  res_use_rd_q;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  assign push_ext = 64'(in_data_i.push_data);
  assign rd_ext   = 64'(rd_q);
  assign occ_ext  = 32'(occ_q);
  assign wr_data  = cmd_i.wr_rot ? rd_q : push_ext[DATA_WIDTH-1:0];

  // element memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[tail_q] <= wr_data;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[head_q];
    end
  end

  always_comb begin
    head_d = cmd_i.head_inc ? ptr_next(head_q) : head_q;
    tail_d = cmd_i.tail_inc ? ptr_next(tail_q) : tail_q;
    occ_d  = occ_q;
    if (cmd_i.occ_inc) begin
      occ_d = occ_q + OW'(1);
    end else if (cmd_i.occ_dec) begin
      occ_d = occ_q - OW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_cap) begin
      res_status_q <= cmd_i.res_status;
      res_use_rd_q <= cmd_i.res_use_rd;
    end
  end

  assign stat_o.empty    = (occ_q == '0);
  assign stat_o.full     = (occ_q == OW'(DEPTH));
  assign stat_o.multi    = (occ_q > OW'(1));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d            = out_q;
    out_valid_d      = out_valid_q;
    if (cmd_i.out_load) begin
      out_d.read_data  = res_use_rd_q ? rd_ext[RD_W-1:0] : '0;
      out_d.status     = STATUS_W'(res_status_q);
      out_d.fill_count = occ_ext[FILL_W-1:0];
      out_d.is_empty   = stat_o.empty;
      out_d.is_full    = stat_o.full;
      out_valid_d      = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(DEPTH))
    else $error("occupancy beyond depth");

  a_ptr_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((32'(head_q) + 32'(occ_q) >= DEPTH) ? (32'(head_q) + 32'(occ_q) - DEPTH)
                                        : (32'(head_q) + 32'(occ_q)))
      == 32'(tail_q))
    else $error("tail pointer disagrees with head plus occupancy");
`endif

endmodule

### sv/circular_fifo_with_rotate_top.sv
// ----------------------------------------------------------------------------
// circular_fifo_with_rotate_top
// Fixed-depth circular fifo taking push, pop, peek and rotate commands, one
// result beat per command beat.
// ----------------------------------------------------------------------------
// each command is accepted in the idle state, then its result beat is loaded
//   from the respond state, which waits while the output beat is stalled; a
//   rotate that moves data passes through the rotate-write state in between
// a new command is taken only once the previous result is loaded, as set by
//   the single-port element memory, its registered read and controller steps
// reset: pointers and occupancy clear to an empty queue; memory contents are
//   not cleared, entries are only read after being written
module circular_fifo_with_rotate_top #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // command beats
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cfrot_pkg::in_t   in_data_i,
  // result beats
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cfrot_pkg::out_t  out_data_o
);
  import cfrot_pkg::*;

  // control bundle from the state machine, status back from the datapath
  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // the controller takes a command only in its idle state; a finished result
  // may still sit in the output register waiting for the consumer, which lets
  // the next command start before the previous beat has been taken
  cfrot_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .stat_i       (dp_stat),
    .in_stall_o   (in_stall_o),
    .cmd_o        (ctrl_cmd)
  );

  // memory, pointers, occupancy and the output register; a rotate reads the
  // front entry in the accept cycle and writes it at the rear in the next cycle
  cfrot_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
